// ===== hw/rtl/tcw_pkg.sv =====
// Package of the text console writer: sizes, character codes, shared types and the glyph ROM.
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS = 25;
  localparam int unsigned NCELLS = ROWS * COLUMNS;
  localparam int unsigned IDX_W = $clog2(NCELLS);
  localparam int unsigned ROW_W = 5;
  localparam int unsigned COL_W = 7;
  localparam int unsigned GLYPH_W = 64;
  localparam int unsigned ATTR_W = 32;

  localparam logic [ATTR_W-1:0] LIT_ATTR = 32'h8000_7FFF;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_FIRST = 8'h20;
  localparam logic [7:0] CH_LAST = 8'h7F;

  localparam logic ACT_PUT = 1'b0;
  localparam logic ACT_READ = 1'b1;
  localparam logic KIND_PUT = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic accept;
    logic clear_step;
    logic scroll_step;
    logic read_load;
  } cmd_t;

  typedef struct packed {
    logic item_read;
    logic item_scroll;
    logic sweep_last;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic               kind;
    logic [ROW_W-1:0]   cell_row;
    logic [COL_W-1:0]   cell_col;
    logic [ATTR_W-1:0]  attr_word;
    logic [GLYPH_W-1:0] glyph_word;
    logic [ROW_W-1:0]   cursor_row;
    logic [COL_W-1:0]   cursor_col;
    logic               scrolled;
  } result_t;

  localparam logic [31:0] FONT [96] = '{
    32'h00000000, 32'h08421004, 32'h12948000, 32'h15F52BEA,
    32'h1F0707C4, 32'h23222620, 32'h24E4564C, 32'h08420000,
    32'h04421082, 32'h08210844, 32'h144F9140, 32'h084F9080,
    32'h40001088, 32'h00078000, 32'h40001080, 32'h02222200,
    32'h1D19F62E, 32'h08C2109F, 32'h1D11111F, 32'h3E220A2E,
    32'h04654BE2, 32'h3F0F062E, 32'h1F0F462E, 32'h3E111108,
    32'h1D17462E, 32'h1D17844C, 32'h48401080, 32'h48401088,
    32'h04441041, 32'h00F001E0, 32'h08208888, 32'h1D111004,
    32'h1D3ADE0F, 32'h08A8FE31, 32'h3D1F463E, 32'h1D18422E,
    32'h3928C65C, 32'h3F0F421F, 32'h3F0F4210, 32'h1D185E2E,
    32'h231FC631, 32'h1C42108E, 32'h0210862E, 32'h232E4A31,
    32'h2108421F, 32'h23BAC631, 32'h239AD671, 32'h1D18C62E,
    32'h3D18FA10, 32'h1D18C64D, 32'h3D18FA51, 32'h1F07043E,
    32'h3E421084, 32'h2318C62E, 32'h2318C544, 32'h2318D771,
    32'h22A21151, 32'h23151084, 32'h3E22221F, 32'h0E421087,
    32'h00820820, 32'h1C21084E, 32'h08A88000, 32'h0000001F,
    32'h08410000, 32'h00E0BE2F, 32'h210F463E, 32'h00E8C22E,
    32'h0217C62F, 32'h00E8FE0F, 32'h0E8FA108, 32'h5D18BC3E,
    32'h210F4631, 32'h0806108E, 32'h0401085C, 32'h21197251,
    32'h1842108E, 32'h01EAD6B1, 32'h01E8C631, 32'h00E8C62E,
    32'h7D18FA10, 32'h5F18BC21, 32'h21BE4210, 32'h00F8383E,
    32'h09F21083, 32'h0118C62E, 32'h0118C544, 32'h011AD5CA,
    32'h01151151, 32'h5294984C, 32'h01F1111F, 32'h064C1083,
    32'h08401084, 32'h30419098, 32'h1B600000, 32'h00022A3F
  };

  // Spreads the six 5-bit font rows over the 64-bit glyph, dropped by one byte when bit 30 is set.
  function automatic logic [GLYPH_W-1:0] glyph_rom(input logic [6:0] idx);
    logic [31:0]        f;
    logic [GLYPH_W-1:0] v;
    f = FONT[idx];
    v = (GLYPH_W'(f & 32'h3E00_0000) << 25) |
        (GLYPH_W'(f & 32'h01F0_0000) << 22) |
        (GLYPH_W'(f & 32'h000F_8000) << 19) |
        (GLYPH_W'(f & 32'h0000_7C00) << 16) |
        (GLYPH_W'(f & 32'h0000_03E0) << 13) |
        (GLYPH_W'(f & 32'h0000_001F) << 10);
    if ((f & 32'h4000_0000) != 32'h0) begin
      v = v >> 8;
    end
    return v;
  endfunction

endpackage

// ===== hw/rtl/tcw_if.sv =====
// Valid/ready channel interfaces for the console input items and result items.
`timescale 1ns / 1ps

interface tcw_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] char_code;
  logic [4:0] read_row;
  logic [6:0] read_col;

  modport source (output valid, action, char_code, read_row, read_col, input ready);
  modport sink (input valid, action, char_code, read_row, read_col, output ready);
endinterface

interface tcw_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [4:0]  cell_row;
  logic [6:0]  cell_col;
  logic [31:0] attr_word;
  logic [63:0] glyph_word;
  logic [4:0]  cursor_row;
  logic [6:0]  cursor_col;
  logic        scrolled;

  modport source (output valid, kind, cell_row, cell_col, attr_word, glyph_word, cursor_row,
                  cursor_col, scrolled, input ready);
  modport sink (input valid, kind, cell_row, cell_col, attr_word, glyph_word, cursor_row,
                cursor_col, scrolled, output ready);
endinterface

// ===== hw/rtl/text_console_writer.sv =====
// Top level of the text console writer: joins the channels to the controller and datapath.
// Printable and read items each give a result (a read via ST_READ); control items give none.
// A new line on the last row adds a scroll sweep of all ROWS x COLUMNS cells and a drain, input held.
// The sweep is set by the single read and write port of the screen store, one cell per cycle.
// After reset a clearing pass over all ROWS x COLUMNS cells zeroes the store before any item.
`timescale 1ns / 1ps

module text_console_writer import tcw_pkg::*; (
  input logic   clk_i,
  input logic   rst_ni,
  tcw_in_if.sink    in_i,
  tcw_out_if.source out_o
);

  cmd_t    cmd;
  stat_t   stat;
  result_t res;
  logic    in_ready;
  logic    out_valid;

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tcw_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .in_action_i    (in_i.action),
    .in_char_code_i (in_i.char_code),
    .in_read_row_i  (in_i.read_row),
    .in_read_col_i  (in_i.read_col),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_o.ready),
    .out_o          (res)
  );

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid;
  assign out_o.kind       = res.kind;
  assign out_o.cell_row   = res.cell_row;
  assign out_o.cell_col   = res.cell_col;
  assign out_o.attr_word  = res.attr_word;
  assign out_o.glyph_word = res.glyph_word;
  assign out_o.cursor_row = res.cursor_row;
  assign out_o.cursor_col = res.cursor_col;
  assign out_o.scrolled   = res.scrolled;

endmodule

// ===== hw/rtl/tcw_datapath.sv =====
// Datapath of the text console writer: cursor, screen store, sweep counter and result register.
`timescale 1ns / 1ps

module tcw_datapath import tcw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output stat_t            stat_o,
  input  logic             in_action_i,
  input  logic [7:0]       in_char_code_i,
  input  logic [ROW_W-1:0] in_read_row_i,
  input  logic [COL_W-1:0] in_read_col_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output result_t          out_o
);

  logic [GLYPH_W:0]   mem [NCELLS];
  logic [GLYPH_W:0]   rd_data_q;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  logic [GLYPH_W:0]   mem_wd;
  logic [IDX_W-1:0]   mem_ra;

  logic [ROW_W-1:0]   cur_row_q, cur_row_d;
  logic [COL_W-1:0]   cur_col_q, cur_col_d;
  logic [IDX_W-1:0]   cnt_q, cnt_d;
  logic               wr_pend_q;
  logic [IDX_W-1:0]   wr_idx_q;
  logic               wr_bottom_q;
  logic [ROW_W-1:0]   rd_row_q;
  logic [COL_W-1:0]   rd_col_q;
  logic               rd_hit_q;
  logic               out_valid_q;
  result_t            out_q;

  logic               is_read, is_print, scroll, nl_req, read_hit, sweep_last, out_free;
  logic               load_put, load_rd;
  logic [7:0]         col_inc, tab_col;
  logic [IDX_W-1:0]   put_idx, read_idx, sweep_src;
  logic [GLYPH_W-1:0] put_glyph;

  assign is_read  = (in_action_i == ACT_READ);
  assign is_print = !is_read && (in_char_code_i >= CH_FIRST) && (in_char_code_i <= CH_LAST);
  assign col_inc  = {1'b0, cur_col_q} + 8'd1;
  assign tab_col  = ({1'b0, cur_col_q} + 8'd8) & ~8'd7;

  always_comb begin
    nl_req    = 1'b0;
    scroll    = 1'b0;
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    if (is_print) begin
      if (col_inc >= 8'(COLUMNS)) begin
        nl_req = 1'b1;
      end else begin
        cur_col_d = col_inc[COL_W-1:0];
      end
    end else if (!is_read) begin
      if (in_char_code_i == CH_CR) begin
        cur_col_d = '0;
      end else if (in_char_code_i == CH_LF) begin
        nl_req = 1'b1;
      end else if (in_char_code_i == CH_TAB) begin
        if (tab_col >= 8'(COLUMNS)) begin
          nl_req = 1'b1;
        end else begin
          cur_col_d = tab_col[COL_W-1:0];
        end
      end
    end
    if (nl_req) begin
      cur_col_d = '0;
      if (cur_row_q == ROW_W'(ROWS - 1)) begin
        scroll = 1'b1;
      end else begin
        cur_row_d = cur_row_q + ROW_W'(1);
      end
    end
  end

  assign read_hit   = (in_read_row_i < ROW_W'(ROWS)) && (in_read_col_i < COL_W'(COLUMNS));
  assign put_idx    = IDX_W'(cur_row_q) * IDX_W'(COLUMNS) + IDX_W'(cur_col_q);
  assign read_idx   = read_hit ?
                      IDX_W'(in_read_row_i) * IDX_W'(COLUMNS) + IDX_W'(in_read_col_i) : '0;
  assign sweep_src  = (cnt_q < IDX_W'(NCELLS - COLUMNS)) ? cnt_q + IDX_W'(COLUMNS) : cnt_q;
  assign sweep_last = (cnt_q == IDX_W'(NCELLS - 1));
  assign put_glyph  = glyph_rom(7'(in_char_code_i - CH_FIRST));
  assign out_free   = !out_valid_q || out_ready_i;
  assign load_put   = cmd_i.accept && is_print;
  assign load_rd    = cmd_i.read_load;

  assign stat_o = '{item_read: is_read, item_scroll: scroll, sweep_last: sweep_last,
                    out_free: out_free};

  always_comb begin
    mem_we = 1'b0;
    mem_wa = cnt_q;
    mem_wd = '0;
    priority if (cmd_i.clear_step) begin
      mem_we = 1'b1;
    end else if (wr_pend_q) begin
      mem_we = 1'b1;
      mem_wa = wr_idx_q;
      mem_wd = {rd_data_q[GLYPH_W] & !wr_bottom_q, rd_data_q[GLYPH_W-1:0]};
    end else if (load_put) begin
      mem_we = 1'b1;
      mem_wa = put_idx;
      mem_wd = {1'b1, put_glyph};
    end else begin
      mem_we = 1'b0;
    end
  end

  assign mem_ra = cmd_i.scroll_step ? sweep_src : read_idx;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem[mem_ra];
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.clear_step || cmd_i.scroll_step) begin
      cnt_d = sweep_last ? '0 : cnt_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      cnt_q       <= '0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      wr_pend_q <= cmd_i.scroll_step;
      if (cmd_i.accept && !is_read) begin
        cur_row_q <= cur_row_d;
        cur_col_q <= cur_col_d;
      end
      if (load_put || load_rd) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wr_idx_q    <= cnt_q;
    wr_bottom_q <= (cnt_q >= IDX_W'(NCELLS - COLUMNS));
    if (cmd_i.accept) begin
      rd_row_q <= in_read_row_i;
      rd_col_q <= in_read_col_i;
      rd_hit_q <= read_hit;
    end
    if (load_put) begin
      out_q <= '{kind: KIND_PUT, cell_row: cur_row_q, cell_col: cur_col_q,
                 attr_word: LIT_ATTR, glyph_word: put_glyph, cursor_row: cur_row_d,
                 cursor_col: cur_col_d, scrolled: scroll};
    end else if (load_rd) begin
      out_q <= '{kind: KIND_READ, cell_row: rd_row_q, cell_col: rd_col_q,
                 attr_word: (rd_hit_q && rd_data_q[GLYPH_W]) ? LIT_ATTR : '0,
                 glyph_word: rd_hit_q ? rd_data_q[GLYPH_W-1:0] : '0,
                 cursor_row: cur_row_q, cursor_col: cur_col_q, scrolled: 1'b0};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTH
  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_col_q < COL_W'(COLUMNS)) && (cur_row_q < ROW_W'(ROWS)))
    else $error("Cursor has left the screen.");

  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.clear_step && wr_pend_q) && !(load_put && wr_pend_q))
    else $error("Two sources write the screen store in one cycle.");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_put || load_rd) |-> out_free)
    else $error("Result register overwritten before its item was taken.");
`endif

endmodule

// ===== hw/rtl/tcw_ctrl.sv =====
// Controller of the text console writer: sequences the clearing pass, reads and scroll sweeps.
`timescale 1ns / 1ps

module tcw_ctrl import tcw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_READ   = 5'b00100,
    ST_SCROLL = 5'b01000,
    ST_DRAIN  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE) && stat_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  assign cmd_o = '{accept: accept, clear_step: (state_q == ST_CLEAR),
                   scroll_step: (state_q == ST_SCROLL), read_load: (state_q == ST_READ)};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (stat_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          priority if (stat_i.item_read) begin
            state_d = ST_READ;
          end else if (stat_i.item_scroll) begin
            state_d = ST_SCROLL;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
      end
      ST_SCROLL: begin
        if (stat_i.sweep_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTH
  a_read_loads_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && stat_i.item_read) |=> cmd_o.read_load)
    else $error("Read item did not load its result in the following cycle.");

  a_scroll_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !stat_i.item_read && stat_i.item_scroll) |=> cmd_o.scroll_step)
    else $error("Scroll requested but no sweep started.");

  a_sweep_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.scroll_step && stat_i.sweep_last) |=> (state_q == ST_DRAIN) && !in_ready_o)
    else $error("Input taken before the last scroll write completed.");
`endif

endmodule
